@@ rtl/boxf_pkg.sv @@
// ----------------------------------------------------------------------------
// boxf_pkg: shared types and constants of the 3x3 box filter
// Pixel and register widths, the work item passed from the classifier to the
// arithmetic back end, and the reciprocal table used for the mean.
// ----------------------------------------------------------------------------
package boxf_pkg;

  localparam int PIXEL_BITS       = 16;
  localparam int CFG_BITS         = 13;
  localparam int WIDTH_FIELD_BITS = 11;
  localparam int ROW_BITS         = 13;

  localparam logic [ROW_BITS-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [ROW_BITS-1:0] HEIGHT_RESET = 13'd1024;
  localparam int                  WIDTH_RESET  = 1024;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS = QPTR_BITS + 1;

  // Sum widths: three pixels per row, nine per window
  localparam int ROWSUM_BITS = PIXEL_BITS + 2;
  localparam int SUM_BITS    = PIXEL_BITS + 4;

  // Mean = (sum * recip) >> RECIP_SHIFT, exact for every sum a window can make
  localparam int RECIP_SHIFT  = 26;
  localparam int RECIP_BITS   = RECIP_SHIFT + 1;
  localparam int PRODUCT_BITS = SUM_BITS + RECIP_BITS;

  localparam logic [RECIP_BITS-1:0] RECIP_BY_1 = 27'd67108864;
  localparam logic [RECIP_BITS-1:0] RECIP_BY_2 = 27'd33554432;
  localparam logic [RECIP_BITS-1:0] RECIP_BY_3 = 27'd22369622;
  localparam logic [RECIP_BITS-1:0] RECIP_BY_4 = 27'd16777216;
  localparam logic [RECIP_BITS-1:0] RECIP_BY_6 = 27'd11184811;
  localparam logic [RECIP_BITS-1:0] RECIP_BY_9 = 27'd7456541;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // Window columns are indexed top (0), middle (1), bottom (2)
  typedef struct packed {
    pixel_t [2:0] left;
    pixel_t [2:0] centre;
    pixel_t [2:0] right;
    logic         up_en;
    logic         down_en;
    logic         left_en;
    logic         right_en;
    logic         end_of_row;
    logic         end_of_frame;
  } boxf_item_t;

  typedef struct packed {
    logic end_of_row;
    logic end_of_frame;
  } boxf_tag_t;

  // Reciprocal of the neighbour count (1 + extra rows) * (1 + extra columns)
  function automatic logic [RECIP_BITS-1:0] boxf_recip(input logic [1:0] extra_rows,
                                                        input logic [1:0] extra_cols);
    logic [RECIP_BITS-1:0] recip;
    unique case ({extra_rows, extra_cols})
      4'b0000:                   recip = RECIP_BY_1;
      4'b0001, 4'b0100:          recip = RECIP_BY_2;
      4'b0010, 4'b1000:          recip = RECIP_BY_3;
      4'b0101:                   recip = RECIP_BY_4;
      4'b0110, 4'b1001:          recip = RECIP_BY_6;
      4'b1010:                   recip = RECIP_BY_9;
      default:                   recip = RECIP_BY_1;
    endcase
    return recip;
  endfunction

endpackage

@@ rtl/boxf_front.sv @@
// ----------------------------------------------------------------------------
// boxf_front: position tracking, line stores and window of the box filter
// Accepts pixel and drain transactions, keeps two line stores and the window
// taps, and decides which accepted items complete a centre pixel. Each such
// item leaves as a work item with its taps and in-frame masks.
// ----------------------------------------------------------------------------
module boxf_front import boxf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic                  cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic                  operation,
  input  logic [PIXEL_BITS-1:0] pixel_value,
  output logic                  push,
  output boxf_item_t            push_item,
  input  logic                  queue_full
);

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS = COL_BITS + 1;
  localparam logic [WIDTH_BITS-1:0] WIDTH_INIT = (WIDTH_RESET > MAX_WIDTH) ?
                                                 WIDTH_BITS'(MAX_WIDTH) :
                                                 WIDTH_BITS'(WIDTH_RESET);

  logic [WIDTH_BITS-1:0]       frame_width;
  logic [ROW_BITS-1:0]         frame_height;
  logic [WIDTH_FIELD_BITS-1:0] width_field;
  logic [WIDTH_BITS-1:0]       width_value;
  logic [ROW_BITS-1:0]         height_value;

  logic [COL_BITS-1:0]   col;
  logic [COL_BITS-1:0]   col_next;
  logic [ROW_BITS-1:0]   row;
  logic [ROW_BITS-1:0]   row_next;
  logic [WIDTH_BITS-1:0] col_inc;
  logic                  last_col;
  logic                  row_past;
  logic                  row_in_frame;
  logic                  accept;
  logic                  emit_a;
  logic                  emit_b;
  logic                  same_col;
  pixel_t                pix;

  pixel_t                line_upper [MAX_WIDTH];
  pixel_t                line_middle [MAX_WIDTH];
  pixel_t                rd_top;
  pixel_t                rd_mid;
  pixel_t [2:0]          tap_a;
  pixel_t [2:0]          tap_b;
  pixel_t [2:0]          new_col;

  // Handshake: stall only on a full queue
  assign accept      = pixel_valid && !queue_full;
  assign pixel_stall = queue_full;

  // Clamp register writes into their legal ranges
  assign width_field = cfg_data[WIDTH_FIELD_BITS-1:0];

  always_comb begin
    if (width_field == '0) begin
      width_value = WIDTH_BITS'(1);
    end else if (32'(width_field) > MAX_WIDTH) begin
      width_value = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      width_value = WIDTH_BITS'(width_field);
    end
    if (cfg_data == '0) begin
      height_value = ROW_BITS'(1);
    end else if (cfg_data > HEIGHT_LIMIT) begin
      height_value = HEIGHT_LIMIT;
    end else begin
      height_value = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_INIT;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write_en) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= width_value;
      end else begin
        frame_height <= height_value;
      end
    end
  end

  // Position of the current item within the frame and flush rows
  assign col_inc      = {1'b0, col} + WIDTH_BITS'(1);
  assign last_col     = col_inc >= frame_width;
  assign row_past     = row > frame_height;
  assign row_in_frame = row < frame_height;

  always_comb begin
    col_next = col;
    row_next = row;
    priority if (cfg_write_en) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      if (row_past) begin
        col_next = '0;
        row_next = '0;
      end else if (last_col) begin
        col_next = '0;
        row_next = row + ROW_BITS'(1);
      end else begin
        col_next = col_inc[COL_BITS-1:0];
      end
    end else begin
      col_next = col;
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Drains and flush positions feed zeros
  assign pix = (operation == OP_PIXEL && row_in_frame) ? pixel_value : '0;

  // Line stores: write the current column, prefetch the next one
  assign same_col = accept && (col_next == col);

  always_ff @(posedge clk) begin
    if (accept) begin
      line_upper[col]  <= rd_mid;
      line_middle[col] <= pix;
    end
    rd_top <= same_col ? rd_mid : line_upper[col_next];
    rd_mid <= same_col ? pix    : line_middle[col_next];
  end

  // Window: two held columns plus the incoming one
  assign new_col[0] = rd_top;
  assign new_col[1] = rd_mid;
  assign new_col[2] = pix;

  always_ff @(posedge clk) begin
    if (accept) begin
      tap_a <= tap_b;
      tap_b <= new_col;
    end
  end

  // Classify: row start closes the last pixel two rows up, otherwise the
  // centre is the pixel one row up and one column left
  assign emit_a = (col == '0) && (row >= ROW_BITS'(2));
  assign emit_b = (col != '0) && (row != '0) && (row <= frame_height);

  always_comb begin
    push_item.left         = tap_a;
    push_item.centre       = tap_b;
    push_item.right        = new_col;
    push_item.right_en     = emit_b;
    push_item.end_of_row   = emit_a;
    push_item.end_of_frame = emit_a && row_past;
    if (emit_a) begin
      push_item.left_en = frame_width != WIDTH_BITS'(1);
      push_item.up_en   = row != ROW_BITS'(2);
      push_item.down_en = row <= frame_height;
    end else begin
      push_item.left_en = col != COL_BITS'(1);
      push_item.up_en   = row != ROW_BITS'(1);
      push_item.down_en = row < frame_height;
    end
  end

  assign push = accept && (emit_a || emit_b);

endmodule

@@ rtl/boxf_queue.sv @@
// ----------------------------------------------------------------------------
// boxf_queue: work item queue between classifier and arithmetic
// Small register FIFO that lets the front keep taking pixels while the back
// end waits on the result side.
// ----------------------------------------------------------------------------
module boxf_queue import boxf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  boxf_item_t push_item,
  input  logic       pop,
  output boxf_item_t head,
  output logic       full,
  output logic       empty
);

  boxf_item_t             slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCOUNT_BITS-1:0] count;
  logic [QCOUNT_BITS-1:0] count_next;

  assign full  = count == QCOUNT_BITS'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Track occupancy
  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + QCOUNT_BITS'(1);
      2'b01:   count_next = count - QCOUNT_BITS'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      count <= count_next;
    end
  end

endmodule

@@ rtl/boxf_back.sv @@
// ----------------------------------------------------------------------------
// boxf_back: arithmetic pipeline of the box filter
// Masks the taps to the in-frame neighbours, sums them and divides by the
// neighbour count through a reciprocal multiply, then holds the result until
// the receiver takes it.
// ----------------------------------------------------------------------------
module boxf_back import boxf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  boxf_item_t            head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [PIXEL_BITS-1:0] average,
  output logic                  end_of_row,
  output logic                  end_of_frame
);

  logic                          advance;
  logic [2:0][ROWSUM_BITS-1:0]   row_sum;
  logic [1:0]                    extra_rows;
  logic [1:0]                    extra_cols;

  logic                          s1_valid;
  logic [2:0][ROWSUM_BITS-1:0]   s1_row_sum;
  logic [1:0]                    s1_rows;
  logic [1:0]                    s1_cols;
  boxf_tag_t                     s1_tag;

  logic                          s2_valid;
  logic [SUM_BITS-1:0]           s2_sum;
  logic [RECIP_BITS-1:0]         s2_recip;
  boxf_tag_t                     s2_tag;

  logic                          s3_valid;
  logic [PRODUCT_BITS-1:0]       s3_product;
  boxf_tag_t                     s3_tag;

  // Whole pipeline moves unless a finished result is held
  assign advance = !(result_valid && result_stall);
  assign pop     = advance && !empty;

  // Row sums over enabled columns; rows outside the frame drop out
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = (head.left_en ? ROWSUM_BITS'(head.left[i]) : '0)
                 + ROWSUM_BITS'(head.centre[i])
                 + (head.right_en ? ROWSUM_BITS'(head.right[i]) : '0);
    end
    if (!head.up_en) begin
      row_sum[0] = '0;
    end
    if (!head.down_en) begin
      row_sum[2] = '0;
    end
    extra_rows = {1'b0, head.up_en} + {1'b0, head.down_en};
    extra_cols = {1'b0, head.left_en} + {1'b0, head.right_en};
  end

  // Valid bits of each stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= pop;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

  // Payload of each stage
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_row_sum          <= row_sum;
      s1_rows             <= extra_rows;
      s1_cols             <= extra_cols;
      s1_tag.end_of_row   <= head.end_of_row;
      s1_tag.end_of_frame <= head.end_of_frame;

      s2_sum   <= SUM_BITS'(s1_row_sum[0]) + SUM_BITS'(s1_row_sum[1])
                + SUM_BITS'(s1_row_sum[2]);
      s2_recip <= boxf_recip(s1_rows, s1_cols);
      s2_tag   <= s1_tag;

      s3_product <= PRODUCT_BITS'(s2_sum) * PRODUCT_BITS'(s2_recip);
      s3_tag     <= s2_tag;

      average      <= s3_product[RECIP_SHIFT +: PIXEL_BITS];
      end_of_row   <= s3_tag.end_of_row;
      end_of_frame <= s3_tag.end_of_frame;
    end
  end

endmodule

@@ rtl/box_filter_3x3_edge_normalized_core.sv @@
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_normalized_core: streaming 3x3 mean filter
// Takes one pixel or drain transaction per clock as long as the result side
// keeps up; the pace is set by the two line stores, each a memory of
// MAX_WIDTH entries with one write and one read per cycle, read one item
// ahead. A result for the pixel one row up and one column left comes out of
// a four-stage sum, reciprocal-multiply pipeline, so in stream terms results
// lag by one row plus one pixel and frame_width + 1 drain transactions after
// the last pixel flush the final row. A four-entry queue between the
// classifier and the arithmetic absorbs short stalls on the result side.
// Writing frame_width or frame_height restarts the frame position; line
// stores need no clearing after reset.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_normalized_core import boxf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic                  cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic                  operation,
  input  logic [PIXEL_BITS-1:0] pixel_value,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [PIXEL_BITS-1:0] average,
  output logic                  end_of_row,
  output logic                  end_of_frame
);

  logic       push;
  boxf_item_t push_item;
  logic       pop;
  boxf_item_t head;
  logic       queue_full;
  logic       queue_empty;

  // Classify items and keep the neighbourhood
  boxf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .operation    (operation),
    .pixel_value  (pixel_value),
    .push         (push),
    .push_item    (push_item),
    .queue_full   (queue_full)
  );

  // Decouple front and back
  boxf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  // Compute the means
  boxf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (queue_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average      (average),
    .end_of_row   (end_of_row),
    .end_of_frame (end_of_frame)
  );

endmodule

@@ rtl/boxf_checker.sv @@
// ----------------------------------------------------------------------------
// boxf_checker: port-level checks of the box filter
// Watches the result channel and the input stall over time.
// ----------------------------------------------------------------------------
module boxf_checker import boxf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  pixel_stall,
  input logic                  result_valid,
  input logic                  result_stall,
  input logic [PIXEL_BITS-1:0] average,
  input logic                  end_of_row,
  input logic                  end_of_frame
);

  // Hold a stalled result transaction
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(average)
                                     && $stable(end_of_row) && $stable(end_of_frame))
    else $error("stalled result changed");

  // Frame end falls on a row end
  a_frame_ends_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && end_of_frame |-> end_of_row)
    else $error("end_of_frame without end_of_row");

  // Input stall starts only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_stall) |-> $past(result_valid && result_stall))
    else $error("input stalled while results flowed");

endmodule

bind box_filter_3x3_edge_normalized_core boxf_checker u_checker (.*);

@@ tb/box_filter_3x3_edge_normalized_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_normalized_core_tb: self-checking bench of the 3x3 mean
// Streams raster frames of many sizes through the filter with random idle
// cycles on both handshakes, and compares every result against a cycle-free
// model of the line stores, window and edge-normalized mean.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_normalized_core_tb;
  import boxf_pkg::*;

  localparam int LINE_DEPTH    = 1024;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 680;
  localparam int EXTREME_ITEMS = 24;

  typedef struct packed {
    pixel_t mean;
    logic   row_end;
    logic   frame_end;
  } window_mean_t;

  // Mirror of the filter: line stores, window taps, stream position, registers
  class box_mean_ledger;
    pixel_t       upper_line [LINE_DEPTH];
    pixel_t       middle_line[LINE_DEPTH];
    pixel_t       taps[3][3];
    int unsigned  col, row, frame_w, frame_h;
    int unsigned  failures;
    window_mean_t expected_means[$];

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (taps[i, j]) taps[i][j] = '0;
      col      = 0;
      row      = 0;
      frame_w  = WIDTH_RESET;
      frame_h  = 32'(HEIGHT_RESET);
      failures = 0;
    endfunction

    // Clamp and store a register; any write restarts the frame
    function void write_reg(reg_index_t idx, logic [CFG_BITS-1:0] data);
      int unsigned v;
      if (idx == REG_FRAME_WIDTH) begin
        v = 32'(data[WIDTH_FIELD_BITS-1:0]);
        if (v == 0) v = 1;
        if (v > LINE_DEPTH) v = LINE_DEPTH;
        frame_w = v;
      end else begin
        v = 32'(data);
        if (v == 0) v = 1;
        if (v > 32'(HEIGHT_LIMIT)) v = 32'(HEIGHT_LIMIT);
        frame_h = v;
      end
      row = 0;
      col = 0;
    endfunction

    // Mean of the in-frame taps around centre (yc, xc), centre in window column ccol
    function void push_mean(int unsigned yc, int unsigned xc, int ccol);
      int unsigned  sum, count;
      int           wc;
      window_mean_t e;
      sum   = 0;
      count = 0;
      for (int di = -1; di <= 1; di++) begin
        if (di < 0 && yc == 0) continue;
        if (di > 0 && yc + 1 >= frame_h) continue;
        for (int dj = -1; dj <= 1; dj++) begin
          wc = ccol + dj;
          if (dj < 0 && xc == 0) continue;
          if (dj > 0 && xc + 1 >= frame_w) continue;
          if (wc < 0 || wc > 2) continue;
          sum += 32'(taps[di + 1][wc]);
          count++;
        end
      end
      if (count == 0) count = 1;
      e.mean      = pixel_t'(sum / count);
      e.row_end   = (xc + 1 == frame_w);
      e.frame_end = (xc + 1 == frame_w) && (yc + 1 == frame_h);
      expected_means.push_back(e);
    endfunction

    // Advance the model by one accepted transaction
    function void take_pixel(op_t op, pixel_t value);
      int unsigned r, c;
      pixel_t      v, top, mid;
      r = row;
      c = col;
      // drain inside the frame counts as zero; data in flush positions is ignored
      v = (op == OP_PIXEL && r < frame_h) ? value : '0;
      // last pixel of a row finishes when the row two below it starts
      if (c == 0 && r >= 2) push_mean(r - 2, frame_w - 1, 2);
      top = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = v;
      for (int i = 0; i < 3; i++) begin
        taps[i][0] = taps[i][1];
        taps[i][1] = taps[i][2];
      end
      taps[0][2] = top;
      taps[1][2] = mid;
      taps[2][2] = v;
      if (c >= 1 && r >= 1 && r <= frame_h) push_mean(r - 1, c - 1, 1);
      if (r >= frame_h + 1) begin
        row = 0;
        col = 0;
      end else begin
        c++;
        if (c >= frame_w) begin
          c = 0;
          r++;
        end
        row = r;
        col = c;
      end
    endfunction

    // Compare an accepted result with the oldest expected mean
    function void match_mean(pixel_t mean, logic row_end, logic frame_end);
      window_mean_t e;
      if (expected_means.size() == 0) begin
        $display("%0t: result expected none actual mean %h row_end %b frame_end %b",
                 $time, mean, row_end, frame_end);
        failures++;
        return;
      end
      e = expected_means.pop_front();
      if (mean !== e.mean) begin
        $display("%0t: average expected %h actual %h", $time, e.mean, mean);
        failures++;
      end
      if (row_end !== e.row_end) begin
        $display("%0t: end_of_row expected %b actual %b", $time, e.row_end, row_end);
        failures++;
      end
      if (frame_end !== e.frame_end) begin
        $display("%0t: end_of_frame expected %b actual %b", $time, e.frame_end, frame_end);
        failures++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write_en;
  logic                cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  logic                pixel_valid;
  logic                pixel_stall;
  logic                operation;
  pixel_t              pixel_value;
  logic                result_valid;
  logic                result_stall;
  pixel_t              average;
  logic                end_of_row;
  logic                end_of_frame;

  box_mean_ledger ledger;
  bit             sender_quiet;
  bit             receiver_quiet;
  int             items_sent;

  box_filter_3x3_edge_normalized_core #(
    .MAX_WIDTH(LINE_DEPTH)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .operation   (operation),
    .pixel_value (pixel_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .average     (average),
    .end_of_row  (end_of_row),
    .end_of_frame(end_of_frame)
  );

  always #2 clk = ~clk;

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(op_t op, pixel_t value);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    operation   <= op;
    pixel_value <= value;
    do @(posedge clk); while (pixel_stall);
    ledger.take_pixel(op, value);
    items_sent++;
  endtask

  // Hold off until every expected mean is out and the pipeline is empty
  task automatic settle();
    pixel_valid <= 1'b0;
    while (ledger.expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write either or both registers on an idle block
  task automatic configure(bit do_w, logic [CFG_BITS-1:0] w_raw,
                           bit do_h, logic [CFG_BITS-1:0] h_raw);
    settle();
    if (do_w) begin
      cfg_write_en <= 1'b1;
      cfg_index    <= REG_FRAME_WIDTH;
      cfg_data     <= w_raw;
      @(posedge clk);
      ledger.write_reg(REG_FRAME_WIDTH, w_raw);
    end
    if (do_h) begin
      cfg_write_en <= 1'b1;
      cfg_index    <= REG_FRAME_HEIGHT;
      cfg_data     <= h_raw;
      @(posedge clk);
      ledger.write_reg(REG_FRAME_HEIGHT, h_raw);
    end
    cfg_write_en <= 1'b0;
  endtask

  // One frame plus its flush; fill < 0 means random content
  task automatic send_frame(int fill, bit cut_short);
    int     area, total, stop_at;
    op_t    op;
    pixel_t value;
    area    = ledger.frame_w * ledger.frame_h;
    total   = area + ledger.frame_w + 1;
    stop_at = (cut_short && total > 1) ? $urandom_range(1, total - 1) : total;
    for (int k = 0; k < stop_at; k++) begin
      if (k < area) begin
        if (fill >= 0) begin
          op    = OP_PIXEL;
          value = fill[PIXEL_BITS-1:0];
        end else begin
          op = ($urandom_range(0, 11) == 0) ? OP_DRAIN : OP_PIXEL;
          case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = '1;
            default: value = pixel_t'($urandom);
          endcase
        end
      end else begin
        // flush positions: drain or data, either way no pixel enters
        op    = op_t'($urandom_range(0, 1));
        value = pixel_t'($urandom);
      end
      send_item(op, value);
    end
  endtask

  // Result side: random stall before each transaction
  initial begin : result_sink
    int hold;
    result_stall <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      hold = receiver_quiet ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      ledger.match_mean(average, end_of_row, end_of_frame);
    end
  end

  initial begin : stimulus
    int w, h, frames, pick;
    ledger       = new();
    rst          <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_index    <= REG_FRAME_WIDTH;
    cfg_data     <= '0;
    pixel_valid  <= 1'b0;
    operation    <= OP_PIXEL;
    pixel_value  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full-scale window, zero pixels with a drain, single-pixel frame
    configure(1'b1, 13'd3, 1'b1, 13'd3);
    send_frame(16'hFFFF, 1'b0);
    configure(1'b1, 13'd2, 1'b1, 13'd2);
    send_item(OP_PIXEL, 16'h0000);
    send_item(OP_DRAIN, 16'h1234);
    send_item(OP_PIXEL, 16'hFFFF);
    send_item(OP_PIXEL, 16'h8001);
    send_item(OP_PIXEL, 16'hABCD);
    send_item(OP_DRAIN, 16'hFFFF);
    send_item(OP_DRAIN, 16'h0000);
    configure(1'b1, 13'd1, 1'b1, 13'd1);
    send_frame(16'h5A5A, 1'b0);

    // Random frame sizes, some phases back to back, some frames cut short
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      sender_quiet   = ($urandom_range(0, 4) == 0);
      receiver_quiet = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 3);
      w    = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h    = $urandom_range(1, 6);
      configure(pick != 1, w[CFG_BITS-1:0], pick != 2, h[CFG_BITS-1:0]);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++)
        send_frame(-1, f == frames - 1 && $urandom_range(0, 5) == 0);
    end

    // Register extremes: zero and all-ones clamp to the limits; keep the runs short
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    configure(1'b1, 13'd0, 1'b1, 13'h1FFF);
    for (int k = 0; k < EXTREME_ITEMS; k++)
      send_item(OP_PIXEL, pixel_t'($urandom));
    configure(1'b1, 13'h07FF, 1'b1, 13'd0);
    for (int k = 0; k < EXTREME_ITEMS; k++)
      send_item(OP_PIXEL, pixel_t'($urandom));

    settle();
    if (ledger.failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
